FILE: rtl/core/bsps_pkg.sv
package bsps_pkg;

  // Widths and limits shared by the scheduler and its checker
  localparam int CYCLE_BITS      = 48;
  localparam int MAX_BANKS       = 8;
  localparam int MAX_READ_PORTS  = 2;
  localparam int MAX_WRITE_PORTS = 2;
  localparam int DMA_CLIENTS     = 4;

  // Shared divider: dividend width and divisor width
  localparam int DIVD_W = 24;
  localparam int DIVR_W = 7;

  localparam logic [24:0] CAP_LIMIT    = 25'd16777216;
  localparam logic [6:0]  STRIPE_MAX   = 7'd64;
  localparam logic [12:0] DMA_BEAT_MAX = 13'd4096;

  typedef logic [CYCLE_BITS-1:0] cycle_t;

  // Request types
  localparam logic [1:0] REQ_CPU = 2'd0;
  localparam logic [1:0] REQ_DMA = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_CLIENT = 2'd2;
  localparam logic [1:0] ST_OVF    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_CAPACITY  = 3'd0;
  localparam logic [2:0] CFG_BEAT      = 3'd1;
  localparam logic [2:0] CFG_LATENCY   = 3'd2;
  localparam logic [2:0] CFG_DMA_BEAT  = 3'd3;
  localparam logic [2:0] CFG_DMA_SETUP = 3'd4;
  localparam logic [2:0] CFG_BANKS     = 3'd5;
  localparam logic [2:0] CFG_RD_PORTS  = 3'd6;
  localparam logic [2:0] CFG_WR_PORTS  = 3'd7;

endpackage

FILE: rtl/core/banked_scratchpad_port_scheduler.sv
// Banked scratchpad port scheduler.
// Request channel: drive the request fields and raise start; the request is
// taken at a rising edge with start high and busy low. busy stays high until
// the result is presented.
// Result channel: done pulses for one cycle with start_cycle, done_cycle,
// service_cycles, queue_cycles, conflict_count and status. The receiver cannot
// stall; a result must be captured in its done cycle. busy is already low in
// that cycle, so a new request may be taken there.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// at a rising edge; write only while busy is low.
// Sequence: a rejected request (bad client, range) is reported via the fail
// state. Otherwise four passes of the shared 24-step restoring divider (offset
// and beat size split into stripe and bank) are followed by a setup state; the
// beats then pass one by one through the bank port tables, and a commit state
// ends the request. The divider and the single beat path set the duration.
// Reset: synchronous, active high. Registers return to their default values,
// all port and DMA engine free times clear to zero, no result is pending.
module banked_scratchpad_port_scheduler #(
  parameter int MAX_BANKS       = bsps_pkg::MAX_BANKS,
  parameter int MAX_READ_PORTS  = bsps_pkg::MAX_READ_PORTS,
  parameter int MAX_WRITE_PORTS = bsps_pkg::MAX_WRITE_PORTS,
  parameter int DMA_CLIENTS     = bsps_pkg::DMA_CLIENTS
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [24:0]           cfg_data,
  // request
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type,
  input  bsps_pkg::cycle_t      now_cycle,
  input  logic [23:0]           start_offset,
  input  logic [24:0]           length_bytes,
  input  logic                  is_write,
  input  logic [1:0]            dma_client,
  input  logic                  charge_setup,
  // result
  output logic                  done,
  output bsps_pkg::cycle_t      start_cycle,
  output bsps_pkg::cycle_t      done_cycle,
  output bsps_pkg::cycle_t      service_cycles,
  output bsps_pkg::cycle_t      queue_cycles,
  output logic [24:0]           conflict_count,
  output logic [1:0]            status
);

  localparam int CW  = (DMA_CLIENTS > 1) ? $clog2(DMA_CLIENTS) : 1;
  localparam int BW  = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
  localparam int RPW = (MAX_READ_PORTS > 1) ? $clog2(MAX_READ_PORTS) : 1;
  localparam int WPW = (MAX_WRITE_PORTS > 1) ? $clog2(MAX_WRITE_PORTS) : 1;
  localparam int CB  = bsps_pkg::CYCLE_BITS;
  localparam int DDW = bsps_pkg::DIVD_W;
  localparam int DRW = bsps_pkg::DIVR_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DLOAD = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_BEAT  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_FAIL  = 3'd7;

  logic [2:0] state;

  // configuration registers
  logic [24:0] cap_r;
  logic [6:0]  bw_r;
  logic [7:0]  lat_r;
  logic [12:0] dbeat_r;
  logic [15:0] setup_r;
  logic [3:0]  banks_r;
  logic [1:0]  rdp_r;
  logic [1:0]  wrp_r;

  // clamped configuration
  logic [24:0] cap_cl;
  logic [6:0]  stripe;
  logic [7:0]  lat_cl;
  logic [12:0] dbeat_cl;
  logic [6:0]  banks_cl;
  logic [3:0]  nr;
  logic [3:0]  nw;

  // latched request
  logic [1:0]  q_type;
  bsps_pkg::cycle_t q_now;
  logic [23:0] q_off;
  logic [24:0] q_len;
  logic        q_wr;
  logic [1:0]  q_cli;
  logic        q_setup;

  logic        is_dma;
  logic        dir_wr;
  logic [12:0] beat_sz;
  logic [15:0] setupc;
  logic [CW-1:0] cidx;

  // timing state
  bsps_pkg::cycle_t eng_free [DMA_CLIENTS];
  bsps_pkg::cycle_t rd_free  [MAX_READ_PORTS][MAX_BANKS];
  bsps_pkg::cycle_t wr_free  [MAX_WRITE_PORTS][MAX_BANKS];
  bsps_pkg::cycle_t rd_work  [MAX_READ_PORTS][MAX_BANKS];
  bsps_pkg::cycle_t wr_work  [MAX_WRITE_PORTS][MAX_BANKS];

  // per-request working registers
  bsps_pkg::cycle_t start_c;
  bsps_pkg::cycle_t issue;
  bsps_pkg::cycle_t done_c;
  logic [24:0] conflicts;
  logic [24:0] rem_len;
  logic [BW-1:0] bank;
  logic [BW-1:0] bqm;
  logic [DRW-1:0] brem;
  logic [DRW-1:0] br;
  logic [DDW-1:0] bq;

  // shared divider
  logic [DDW-1:0] div_a;
  logic [DRW-1:0] div_r;
  logic [DRW-1:0] div_d;
  logic [4:0]     div_cnt;
  logic [1:0]     div_op;
  logic [DRW:0]   div_part;
  logic [DRW:0]   div_sub;
  logic           div_ge;

  // beat path
  bsps_pkg::cycle_t rbest_v;
  bsps_pkg::cycle_t wbest_v;
  logic [RPW-1:0]   rbest_k;
  logic [WPW-1:0]   wbest_k;
  bsps_pkg::cycle_t pv;
  bsps_pkg::cycle_t sel;
  logic             conflict;
  logic [CB:0]      sel_p1;
  logic [CB:0]      fin;
  logic [CB:0]      iss_p1;
  logic             ovf_b;
  logic [DRW:0]     rsum;
  logic             carry;
  logic [DRW-1:0]   brem_next;
  logic [7:0]       bsum;
  logic [BW-1:0]    bank_next;

  logic [CB:0]      setup_sum;
  logic [25:0]      end_addr;
  bsps_pkg::cycle_t eng_v;

  assign busy = (state != S_IDLE);

  // clamp configuration to legal ranges
  always_comb begin
    cap_cl   = (cap_r > bsps_pkg::CAP_LIMIT) ? bsps_pkg::CAP_LIMIT : cap_r;
    stripe   = (bw_r == 7'd0) ? 7'd1 : ((bw_r > bsps_pkg::STRIPE_MAX) ?
               bsps_pkg::STRIPE_MAX : bw_r);
    lat_cl   = (lat_r == 8'd0) ? 8'd1 : lat_r;
    dbeat_cl = (dbeat_r == 13'd0) ? 13'd1 : ((dbeat_r > bsps_pkg::DMA_BEAT_MAX) ?
               bsps_pkg::DMA_BEAT_MAX : dbeat_r);
    banks_cl = (banks_r == 4'd0) ? 7'd1 : (({3'b0, banks_r} > 7'(MAX_BANKS)) ?
               7'(MAX_BANKS) : {3'b0, banks_r});
    nr       = (rdp_r == 2'd0) ? 4'd1 : (({2'b0, rdp_r} > 4'(MAX_READ_PORTS)) ?
               4'(MAX_READ_PORTS) : {2'b0, rdp_r});
    nw       = (wrp_r == 2'd0) ? 4'd1 : (({2'b0, wrp_r} > 4'(MAX_WRITE_PORTS)) ?
               4'(MAX_WRITE_PORTS) : {2'b0, wrp_r});
  end

  // request decode
  always_comb begin
    is_dma  = (q_type == bsps_pkg::REQ_DMA);
    dir_wr  = ((q_type == bsps_pkg::REQ_CPU) || (q_type == bsps_pkg::REQ_DMA)) && q_wr;
    beat_sz = is_dma ? dbeat_cl : {6'b0, stripe};
    setupc  = (is_dma && q_setup) ? setup_r : 16'd0;
    cidx    = CW'(q_cli);
    eng_v   = eng_free[cidx];
    end_addr  = {2'b0, q_off} + {1'b0, q_len};
    setup_sum = {1'b0, start_c} + {(CB-15)'(0), setupc};
  end

  // divider step
  always_comb begin
    div_part = {div_r, div_a[DDW-1]};
    div_ge   = (div_part >= {1'b0, div_d});
    div_sub  = div_part - {1'b0, div_d};
  end

  // earliest-free port of the current bank, lowest index on a tie
  always_comb begin
    rbest_v = rd_work[0][bank];
    rbest_k = '0;
    for (int k = 1; k < MAX_READ_PORTS; k++) begin
      if ((k < int'(nr)) && (rd_work[k][bank] < rbest_v)) begin
        rbest_v = rd_work[k][bank];
        rbest_k = RPW'(k);
      end
    end
    wbest_v = wr_work[0][bank];
    wbest_k = '0;
    for (int k = 1; k < MAX_WRITE_PORTS; k++) begin
      if ((k < int'(nw)) && (wr_work[k][bank] < wbest_v)) begin
        wbest_v = wr_work[k][bank];
        wbest_k = WPW'(k);
      end
    end
  end

  // beat issue and bank advance
  always_comb begin
    pv        = dir_wr ? wbest_v : rbest_v;
    conflict  = (pv > issue);
    sel       = conflict ? pv : issue;
    sel_p1    = {1'b0, sel} + (CB+1)'(1);
    fin       = {1'b0, sel} + {(CB-7)'(0), lat_cl};
    iss_p1    = {1'b0, issue} + (CB+1)'(1);
    ovf_b     = sel_p1[CB] | fin[CB] | iss_p1[CB];
    rsum      = {1'b0, brem} + {1'b0, br};
    carry     = (rsum >= {1'b0, stripe});
    brem_next = carry ? DRW'(rsum - {1'b0, stripe}) : rsum[DRW-1:0];
    bsum      = 8'(bank) + 8'(bqm) + {7'b0, carry};
    bank_next = (bsum >= {1'b0, banks_cl}) ? BW'(bsum - {1'b0, banks_cl}) : BW'(bsum);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_r   <= 25'd65536;
      bw_r    <= 7'd8;
      lat_r   <= 8'd1;
      dbeat_r <= 13'd8;
      setup_r <= 16'd0;
      banks_r <= 4'd8;
      rdp_r   <= 2'd1;
      wrp_r   <= 2'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bsps_pkg::CFG_CAPACITY:  cap_r   <= cfg_data;
        bsps_pkg::CFG_BEAT:      bw_r    <= cfg_data[6:0];
        bsps_pkg::CFG_LATENCY:   lat_r   <= cfg_data[7:0];
        bsps_pkg::CFG_DMA_BEAT:  dbeat_r <= cfg_data[12:0];
        bsps_pkg::CFG_DMA_SETUP: setup_r <= cfg_data[15:0];
        bsps_pkg::CFG_BANKS:     banks_r <= cfg_data[3:0];
        bsps_pkg::CFG_RD_PORTS:  rdp_r   <= cfg_data[1:0];
        bsps_pkg::CFG_WR_PORTS:  wrp_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int c = 0; c < DMA_CLIENTS; c++) eng_free[c] <= '0;
      for (int k = 0; k < MAX_READ_PORTS; k++)
        for (int b = 0; b < MAX_BANKS; b++) rd_free[k][b] <= '0;
      for (int k = 0; k < MAX_WRITE_PORTS; k++)
        for (int b = 0; b < MAX_BANKS; b++) wr_free[k][b] <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            q_type  <= req_type;
            q_now   <= now_cycle;
            q_off   <= start_offset;
            q_len   <= length_bytes;
            q_wr    <= is_write;
            q_cli   <= dma_client;
            q_setup <= charge_setup;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          rd_work <= rd_free;
          wr_work <= wr_free;
          start_c <= (is_dma && (eng_v > q_now)) ? eng_v : q_now;
          div_op  <= 2'd0;
          if (is_dma && ({30'b0, q_cli} >= 32'(DMA_CLIENTS))) begin
            status <= bsps_pkg::ST_CLIENT;
            state  <= S_FAIL;
          end else if ((q_len == 25'd0) || (end_addr > {1'b0, cap_cl})) begin
            status <= bsps_pkg::ST_RANGE;
            state  <= S_FAIL;
          end else begin
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          // operands for the next division pass
          div_r   <= '0;
          div_cnt <= '0;
          unique case (div_op)
            2'd0: begin div_a <= q_off;               div_d <= stripe;   end
            2'd1: begin div_a <= bq;                  div_d <= banks_cl; end
            2'd2: begin div_a <= DDW'(beat_sz);       div_d <= stripe;   end
            default: begin div_a <= bq;               div_d <= banks_cl; end
          endcase
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt != 5'(DDW)) begin
            div_a   <= {div_a[DDW-2:0], div_ge};
            div_r   <= div_ge ? div_sub[DRW-1:0] : div_part[DRW-1:0];
            div_cnt <= div_cnt + 5'd1;
          end else begin
            // bq holds the offset quotient between the first two passes
            unique case (div_op)
              2'd0: begin bq <= div_a; brem <= div_r; end
              2'd1: bank <= BW'(div_r);
              2'd2: begin bq <= div_a; br <= div_r; end
              default: bqm <= BW'(div_r);
            endcase
            div_op <= div_op + 2'd1;
            state  <= (div_op == 2'd3) ? S_SETUP : S_DLOAD;
          end
        end
        S_SETUP: begin
          issue     <= setup_sum[CB-1:0];
          done_c    <= setup_sum[CB-1:0];
          conflicts <= '0;
          rem_len   <= q_len;
          if (setup_sum[CB]) begin
            status <= bsps_pkg::ST_OVF;
            state  <= S_FAIL;
          end else begin
            state <= S_BEAT;
          end
        end
        S_BEAT: begin
          if (dir_wr) wr_work[wbest_k][bank] <= sel_p1[CB-1:0];
          else        rd_work[rbest_k][bank] <= sel_p1[CB-1:0];
          if (fin[CB-1:0] > done_c) done_c <= fin[CB-1:0];
          if (conflict) conflicts <= conflicts + 25'd1;
          issue <= iss_p1[CB-1:0];
          brem  <= brem_next;
          bank  <= bank_next;
          if (ovf_b) begin
            status <= bsps_pkg::ST_OVF;
            state  <= S_FAIL;
          end else if (rem_len <= {12'b0, beat_sz}) begin
            state <= S_FIN;
          end else begin
            rem_len <= rem_len - {12'b0, beat_sz};
          end
        end
        S_FIN: begin
          rd_free <= rd_work;
          wr_free <= wr_work;
          if (is_dma) eng_free[cidx] <= done_c;
          start_cycle    <= start_c;
          done_cycle     <= done_c;
          service_cycles <= done_c - start_c;
          queue_cycles   <= is_dma ? (start_c - q_now) : '0;
          conflict_count <= conflicts;
          status         <= bsps_pkg::ST_OK;
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        S_FAIL: begin
          start_cycle    <= '0;
          done_cycle     <= '0;
          service_cycles <= '0;
          queue_cycles   <= '0;
          conflict_count <= '0;
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/bsps_checker.sv
module bsps_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input bsps_pkg::cycle_t start_cycle,
  input bsps_pkg::cycle_t done_cycle,
  input bsps_pkg::cycle_t service_cycles,
  input logic [1:0]       status
);

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // a result is one cycle long
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // the block is free again when the result shows
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while result presented");

  // failed transactions carry zero timing fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != bsps_pkg::ST_OK)) |->
      ((start_cycle == '0) && (done_cycle == '0) && (service_cycles == '0)))
    else $error("error result with nonzero fields");

  // service time is completion minus start
  a_service: assert property (@(posedge clk) disable iff (rst)
    (done && (status == bsps_pkg::ST_OK)) |->
      (service_cycles == (done_cycle - start_cycle)))
    else $error("service cycles mismatch");

endmodule

bind banked_scratchpad_port_scheduler bsps_checker u_bsps_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .start_cycle    (start_cycle),
  .done_cycle     (done_cycle),
  .service_cycles (service_cycles),
  .status         (status)
);
